FILE: hw/rtl/c8x_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the CHIP-8/SCHIP execute core.
// No dependencies.
package c8x_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int STK_IDX_W   = $clog2(STACK_DEPTH);
    localparam int STK_CNT_W   = $clog2(STACK_DEPTH + 1);

    localparam logic [15:0] RESET_PC     = 16'h0200;
    localparam logic [15:0] HIRES_WORD   = 16'h1260;
    localparam logic [15:0] HIRES_TARGET = 16'h02C0;
    localparam logic [15:0] FONT_BIG_BASE = 16'h0050;

    // command codes of the input item
    localparam logic [1:0] CMD_EXEC = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_LOAD = 2'd2;
    localparam logic [1:0] CMD_COLL = 2'd3;

    // result kinds
    localparam logic [3:0] KIND_STATUS = 4'd0;
    localparam logic [3:0] KIND_WRITE  = 4'd1;
    localparam logic [3:0] KIND_READ   = 4'd2;
    localparam logic [3:0] KIND_DRAW   = 4'd3;
    localparam logic [3:0] KIND_CLEAR  = 4'd4;
    localparam logic [3:0] KIND_SCR_DN = 4'd5;
    localparam logic [3:0] KIND_SCR_RT = 4'd6;
    localparam logic [3:0] KIND_SCR_LT = 4'd7;
    localparam logic [3:0] KIND_MODE   = 4'd8;
    localparam logic [3:0] KIND_BEEP   = 4'd9;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_STOPPED   = 3'd1;
    localparam logic [2:0] ERR_UNIMPL    = 3'd2;
    localparam logic [2:0] ERR_UNDERFLOW = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

    // display modes
    localparam logic [1:0] MODE_PLAIN   = 2'd0;
    localparam logic [1:0] MODE_SCHIP   = 2'd1;
    localparam logic [1:0] MODE_HIRES64 = 2'd2;

    // configuration register indexes
    localparam logic CFG_SHIFT_SRC = 1'b0;
    localparam logic CFG_START     = 1'b1;

    // system words
    localparam logic [11:0] SYS_SCROLL_DN = 12'h00C;
    localparam logic [15:0] SYS_CLS       = 16'h00E0;
    localparam logic [15:0] SYS_CLS_ALT   = 16'h0230;
    localparam logic [15:0] SYS_RET       = 16'h00EE;
    localparam logic [15:0] SYS_SCR_RT    = 16'h00FB;
    localparam logic [15:0] SYS_SCR_LT    = 16'h00FC;
    localparam logic [15:0] SYS_EXIT      = 16'h00FD;
    localparam logic [15:0] SYS_LORES     = 16'h00FE;
    localparam logic [15:0] SYS_HIRES     = 16'h00FF;

    // major opcodes
    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SEI  = 4'h3;
    localparam logic [3:0] OP_SNEI = 4'h4;
    localparam logic [3:0] OP_SER  = 4'h5;
    localparam logic [3:0] OP_LDI  = 4'h6;
    localparam logic [3:0] OP_ADDI = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNER = 4'h9;
    localparam logic [3:0] OP_LDIX = 4'hA;
    localparam logic [3:0] OP_JPV0 = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_DRW  = 4'hD;
    localparam logic [3:0] OP_KEY  = 4'hE;

    // ALU sub-ops
    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    // key skip sub-ops
    localparam logic [7:0] KEY_SKP  = 8'h9E;
    localparam logic [7:0] KEY_SKNP = 8'hA1;

    // FX sub-ops
    localparam logic [7:0] FX_GET_DT = 8'h07;
    localparam logic [7:0] FX_WAIT_K = 8'h0A;
    localparam logic [7:0] FX_SET_DT = 8'h15;
    localparam logic [7:0] FX_BEEP   = 8'h18;
    localparam logic [7:0] FX_ADD_I  = 8'h1E;
    localparam logic [7:0] FX_FONT   = 8'h29;
    localparam logic [7:0] FX_FONT_B = 8'h30;
    localparam logic [7:0] FX_BCD    = 8'h33;
    localparam logic [7:0] FX_STORE  = 8'h55;
    localparam logic [7:0] FX_LOAD   = 8'h65;
    localparam logic [7:0] FX_SAVE   = 8'h75;
    localparam logic [7:0] FX_REST   = 8'h85;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_OPER_B,
        ST_EXEC,
        ST_FLAG,
        ST_LOOP,
        ST_STATUS
    } state_t;

    typedef enum logic [2:0] {
        LP_BCD,
        LP_STORE,
        LP_LOAD,
        LP_SAVE,
        LP_RESTORE
    } loop_op_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic [4:0]  count;
        logic [2:0]  error;
        logic [15:0] fetch_pc;
        logic        last;
    } res_t;

    // lowest pressed key; 15 when none
    function automatic logic [3:0] lowest_key(input logic [15:0] btn);
        logic [3:0] k;
        k = 4'hF;
        for (int i = 15; i >= 0; i--) begin
            if (btn[i]) begin
                k = 4'(i);
            end
        end
        return k;
    endfunction

    // {hundreds, tens, ones}, each 4 bits
    function automatic logic [11:0] bcd_digits(input logic [7:0] v);
        logic [3:0]  h;
        logic [6:0]  r;
        logic [14:0] p;
        logic [3:0]  t;
        logic [6:0]  o;
        if (v >= 8'd200) begin
            h = 4'd2;
            r = 7'(v - 8'd200);
        end else if (v >= 8'd100) begin
            h = 4'd1;
            r = 7'(v - 8'd100);
        end else begin
            h = 4'd0;
            r = v[6:0];
        end
        // r / 10 by reciprocal, exact for r < 100
        p = {8'd0, r} * 15'd205;
        t = p[14:11];
        o = r - 7'({3'd0, t} * 7'd10);
        return {h, t, o[3:0]};
    endfunction

endpackage

FILE: hw/rtl/chip8_instruction_execute_core_unit.sv
`timescale 1ns / 1ps
// CHIP-8/SCHIP instruction execute core: sequencer, register file, call stack.
// Depends on c8x_pkg.
//
// Executes one item at a time: an instruction word, a timer tick, a load data
// byte or a collision report. The data registers have a single read port, so
// the sequencer walks each instruction through dispatch, second operand read,
// execute and status. Instructions that also set VF (8XY4..8XYE) add a flag
// step before status; FX55/FX65/FX75/FX85 add a loop with one step per
// register (X+1 steps) and FX33 one with three steps. Ticks, loads, collisions
// and instructions refused while stopped, waiting for a key or waiting for
// loads go through dispatch and status only. Each emitted result also waits
// for the output register to be free, so back-pressure on m_ready stalls the
// sequencer. s_ready is high only between items.
// Every item ends with exactly one status result (kind 0, m_last high) that
// carries the error code and the next fetch address; side effects (memory
// writes, read requests, draw, clear, scroll, mode, beep) come before it.
// Configuration: index 0 selects VX as shift source, index 1 loads the program
// counter. Write it only while the block is idle.
module chip8_instruction_execute_core_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [15:0] s_instruction,
    input  logic [7:0]  s_random_byte,
    input  logic [15:0] s_buttons,
    input  logic [7:0]  s_read_byte,
    input  logic        s_collision,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_kind,
    output logic [15:0] m_addr,
    output logic [7:0]  m_data,
    output logic [7:0]  m_pos_x,
    output logic [7:0]  m_pos_y,
    output logic [4:0]  m_count,
    output logic [2:0]  m_error,
    output logic [15:0] m_fetch_pc,
    output logic        m_last
);

    c8x_pkg::state_t state_reg, state_next;

    // latched input item
    logic [1:0]  cmd_reg, cmd_next;
    logic [15:0] instr_reg, instr_next;
    logic [7:0]  rnd_reg, rnd_next;
    logic [15:0] btn_reg, btn_next;
    logic [7:0]  rb_reg, rb_next;
    logic        col_reg, col_next;

    // operands and scratch
    logic [7:0]  a_reg, a_next;
    logic [7:0]  b_reg, b_next;
    logic        flag_reg, flag_next;
    logic [2:0]  err_reg, err_next;
    logic [11:0] bcd_reg, bcd_next;
    c8x_pkg::loop_op_t loop_op_reg, loop_op_next;
    logic [3:0]  loop_idx_reg, loop_idx_next;
    logic [3:0]  loop_end_reg, loop_end_next;

    // architectural state
    logic        shift_x_reg, shift_x_next;
    logic [15:0] index_reg, index_next;
    logic [15:0] cur_pc_reg, cur_pc_next;
    logic [15:0] next_pc_reg, next_pc_next;
    logic [c8x_pkg::STK_CNT_W-1:0] depth_reg, depth_next;
    logic [7:0]  delay_reg, delay_next;
    logic [15:0] key_mask_reg, key_mask_next;
    logic        awaiting_reg, awaiting_next;
    logic [3:0]  key_dest_reg, key_dest_next;
    logic        running_reg, running_next;
    logic [1:0]  mode_reg, mode_next;
    logic [4:0]  loads_left_reg, loads_left_next;
    logic [3:0]  load_tgt_reg, load_tgt_next;

    // register files
    logic [7:0]  v_reg [16];
    logic [7:0]  sv_reg [16];
    logic [15:0] stk_reg [c8x_pkg::STACK_DEPTH];

    logic        v_we;
    logic [3:0]  v_wa;
    logic [7:0]  v_wd;
    logic [3:0]  v_ra;
    logic [7:0]  v_rd;
    logic        sv_we;
    logic [7:0]  sv_rd;
    logic        stk_we;
    logic [15:0] stk_wd;
    logic [c8x_pkg::STK_IDX_W-1:0] stk_rd_idx;
    logic [15:0] stk_rd;

    // output register
    logic        m_valid_reg, m_valid_next;
    c8x_pkg::res_t res_reg, res_next;

    // shared address adder
    logic [15:0] add_a, add_b, sum;

    // decode of the instruction in EXEC
    logic [2:0]  dec_err;
    logic        dec_emit;
    c8x_pkg::res_t dec_res;
    logic        dec_loop;
    logic        dec_flag;

    logic        emit_req;
    c8x_pkg::res_t emit_res;
    logic        out_free;
    logic        go;
    logic        exec_ok;

    logic [3:0]  op, x, y, n;
    logic [7:0]  nn;
    logic [15:0] nnn;
    logic        hires_start;
    logic        pressed;
    logic        wide;
    logic [7:0]  src;
    logic [8:0]  alu_add;

    assign op  = instr_reg[15:12];
    assign x   = instr_reg[11:8];
    assign y   = instr_reg[7:4];
    assign n   = instr_reg[3:0];
    assign nn  = instr_reg[7:0];
    assign nnn = {4'd0, instr_reg[11:0]};

    assign hires_start = (cur_pc_reg == c8x_pkg::RESET_PC)
                         && (instr_reg == c8x_pkg::HIRES_WORD);
    assign pressed = (a_reg[7:4] == 4'd0) && key_mask_reg[a_reg[3:0]];
    assign wide    = (n == 4'd0) && (mode_reg == c8x_pkg::MODE_SCHIP);
    assign src     = shift_x_reg ? a_reg : b_reg;
    assign alu_add = {1'b0, a_reg} + {1'b0, b_reg};

    assign out_free = !m_valid_reg || m_ready;
    assign go       = !emit_req || out_free;
    assign s_ready  = (state_reg == c8x_pkg::ST_IDLE);
    assign exec_ok  = (cmd_reg == c8x_pkg::CMD_EXEC) && running_reg
                      && !awaiting_reg && (loads_left_reg == 5'd0);

    assign v_rd       = v_reg[v_ra];
    assign sv_rd      = sv_reg[loop_idx_reg];
    assign stk_rd_idx = c8x_pkg::STK_IDX_W'(depth_reg - 1'b1);
    assign stk_rd     = stk_reg[stk_rd_idx];
    assign sum        = add_a + add_b;

    // data register read address
    always_comb begin
        case (state_reg)
            c8x_pkg::ST_DISPATCH: v_ra = (cmd_reg == c8x_pkg::CMD_COLL) ? 4'hF : x;
            c8x_pkg::ST_OPER_B:   v_ra = (op == c8x_pkg::OP_JPV0) ? 4'h0 : y;
            c8x_pkg::ST_LOOP:     v_ra = loop_idx_reg;
            default:              v_ra = x;
        endcase
    end

    // shared adder operands
    always_comb begin
        add_a = next_pc_reg;
        add_b = 16'd2;
        case (state_reg)
            c8x_pkg::ST_EXEC: begin
                if (op == c8x_pkg::OP_JPV0) begin
                    add_a = {8'd0, b_reg};
                    add_b = nnn;
                end else if (op == 4'hF) begin
                    add_a = index_reg;
                    add_b = {8'd0, a_reg};
                end
            end
            c8x_pkg::ST_LOOP: begin
                add_a = index_reg;
                add_b = {12'd0, loop_idx_reg};
            end
            default: begin
                add_a = next_pc_reg;
                add_b = 16'd2;
            end
        endcase
    end

    // instruction decode
    always_comb begin
        dec_err  = c8x_pkg::ERR_NONE;
        dec_emit = 1'b0;
        dec_res  = '0;
        dec_loop = 1'b0;
        dec_flag = 1'b0;
        case (op)
            c8x_pkg::OP_SYS: begin
                if (instr_reg[15:4] == c8x_pkg::SYS_SCROLL_DN) begin
                    dec_emit      = 1'b1;
                    dec_res.kind  = c8x_pkg::KIND_SCR_DN;
                    dec_res.count = {1'b0, n};
                end else begin
                    case (instr_reg)
                        c8x_pkg::SYS_CLS, c8x_pkg::SYS_CLS_ALT: begin
                            dec_emit     = 1'b1;
                            dec_res.kind = c8x_pkg::KIND_CLEAR;
                        end
                        c8x_pkg::SYS_RET: begin
                            if (depth_reg == '0) begin
                                dec_err = c8x_pkg::ERR_UNDERFLOW;
                            end
                        end
                        c8x_pkg::SYS_SCR_RT: begin
                            dec_emit     = 1'b1;
                            dec_res.kind = c8x_pkg::KIND_SCR_RT;
                        end
                        c8x_pkg::SYS_SCR_LT: begin
                            dec_emit     = 1'b1;
                            dec_res.kind = c8x_pkg::KIND_SCR_LT;
                        end
                        c8x_pkg::SYS_EXIT: dec_err = c8x_pkg::ERR_STOPPED;
                        c8x_pkg::SYS_LORES: begin
                            dec_emit     = 1'b1;
                            dec_res.kind = c8x_pkg::KIND_MODE;
                            dec_res.data = {6'd0, c8x_pkg::MODE_PLAIN};
                        end
                        c8x_pkg::SYS_HIRES: begin
                            dec_emit     = 1'b1;
                            dec_res.kind = c8x_pkg::KIND_MODE;
                            dec_res.data = {6'd0, c8x_pkg::MODE_SCHIP};
                        end
                        default: dec_err = c8x_pkg::ERR_UNIMPL;
                    endcase
                end
            end
            c8x_pkg::OP_JP: begin
                if (hires_start) begin
                    dec_emit     = 1'b1;
                    dec_res.kind = c8x_pkg::KIND_MODE;
                    dec_res.data = {6'd0, c8x_pkg::MODE_HIRES64};
                end
            end
            c8x_pkg::OP_CALL: begin
                if (depth_reg >= c8x_pkg::STK_CNT_W'(c8x_pkg::STACK_DEPTH)) begin
                    dec_err = c8x_pkg::ERR_OVERFLOW;
                end
            end
            c8x_pkg::OP_ALU: begin
                case (n)
                    c8x_pkg::ALU_MOV, c8x_pkg::ALU_OR,
                    c8x_pkg::ALU_AND, c8x_pkg::ALU_XOR: dec_flag = 1'b0;
                    c8x_pkg::ALU_ADD, c8x_pkg::ALU_SUB, c8x_pkg::ALU_SHR,
                    c8x_pkg::ALU_SBN, c8x_pkg::ALU_SHL: dec_flag = 1'b1;
                    default: dec_err = c8x_pkg::ERR_UNIMPL;
                endcase
            end
            c8x_pkg::OP_DRW: begin
                dec_emit      = 1'b1;
                dec_res.kind  = c8x_pkg::KIND_DRAW;
                dec_res.addr  = index_reg;
                dec_res.data  = {7'd0, wide};
                dec_res.pos_x = a_reg;
                dec_res.pos_y = b_reg;
                dec_res.count = wide ? 5'd16 : {1'b0, n};
            end
            c8x_pkg::OP_KEY: begin
                if (nn != c8x_pkg::KEY_SKP && nn != c8x_pkg::KEY_SKNP) begin
                    dec_err = c8x_pkg::ERR_UNIMPL;
                end
            end
            4'hF: begin
                case (nn)
                    c8x_pkg::FX_GET_DT, c8x_pkg::FX_WAIT_K, c8x_pkg::FX_SET_DT,
                    c8x_pkg::FX_ADD_I, c8x_pkg::FX_FONT, c8x_pkg::FX_FONT_B:
                        dec_loop = 1'b0;
                    c8x_pkg::FX_BEEP: begin
                        dec_emit     = 1'b1;
                        dec_res.kind = c8x_pkg::KIND_BEEP;
                        dec_res.data = a_reg;
                    end
                    c8x_pkg::FX_BCD, c8x_pkg::FX_STORE, c8x_pkg::FX_LOAD,
                    c8x_pkg::FX_SAVE, c8x_pkg::FX_REST:
                        dec_loop = 1'b1;
                    default: dec_err = c8x_pkg::ERR_UNIMPL;
                endcase
            end
            default: dec_err = c8x_pkg::ERR_NONE;
        endcase
        dec_res.fetch_pc = next_pc_reg;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            c8x_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = c8x_pkg::ST_DISPATCH;
                end
            end
            c8x_pkg::ST_DISPATCH: begin
                state_next = exec_ok ? c8x_pkg::ST_OPER_B : c8x_pkg::ST_STATUS;
            end
            c8x_pkg::ST_OPER_B: state_next = c8x_pkg::ST_EXEC;
            c8x_pkg::ST_EXEC: begin
                if (go) begin
                    if (dec_err != c8x_pkg::ERR_NONE) begin
                        state_next = c8x_pkg::ST_STATUS;
                    end else if (dec_loop) begin
                        state_next = c8x_pkg::ST_LOOP;
                    end else if (dec_flag) begin
                        state_next = c8x_pkg::ST_FLAG;
                    end else begin
                        state_next = c8x_pkg::ST_STATUS;
                    end
                end
            end
            c8x_pkg::ST_FLAG: state_next = c8x_pkg::ST_STATUS;
            c8x_pkg::ST_LOOP: begin
                if (go && loop_idx_reg == loop_end_reg) begin
                    state_next = c8x_pkg::ST_STATUS;
                end
            end
            c8x_pkg::ST_STATUS: begin
                if (go) begin
                    state_next = c8x_pkg::ST_IDLE;
                end
            end
            default: state_next = c8x_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cmd_next        = cmd_reg;
        instr_next      = instr_reg;
        rnd_next        = rnd_reg;
        btn_next        = btn_reg;
        rb_next         = rb_reg;
        col_next        = col_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        flag_next       = flag_reg;
        err_next        = err_reg;
        bcd_next        = bcd_reg;
        loop_op_next    = loop_op_reg;
        loop_idx_next   = loop_idx_reg;
        loop_end_next   = loop_end_reg;
        shift_x_next    = shift_x_reg;
        index_next      = index_reg;
        cur_pc_next     = cur_pc_reg;
        next_pc_next    = next_pc_reg;
        depth_next      = depth_reg;
        delay_next      = delay_reg;
        key_mask_next   = key_mask_reg;
        awaiting_next   = awaiting_reg;
        key_dest_next   = key_dest_reg;
        running_next    = running_reg;
        mode_next       = mode_reg;
        loads_left_next = loads_left_reg;
        load_tgt_next   = load_tgt_reg;
        v_we            = 1'b0;
        v_wa            = x;
        v_wd            = 8'd0;
        sv_we           = 1'b0;
        stk_we          = 1'b0;
        stk_wd          = next_pc_reg;
        emit_req        = 1'b0;
        emit_res        = '0;

        case (state_reg)
            c8x_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_cmd;
                    instr_next = s_instruction;
                    rnd_next   = s_random_byte;
                    btn_next   = s_buttons;
                    rb_next    = s_read_byte;
                    col_next   = s_collision;
                end
            end

            c8x_pkg::ST_DISPATCH: begin
                err_next = c8x_pkg::ERR_NONE;
                case (cmd_reg)
                    c8x_pkg::CMD_EXEC: begin
                        if (!running_reg) begin
                            err_next = c8x_pkg::ERR_STOPPED;
                        end else if (exec_ok) begin
                            cur_pc_next  = next_pc_reg;
                            next_pc_next = sum;
                            a_next       = v_rd;
                        end
                    end
                    c8x_pkg::CMD_TICK: begin
                        key_mask_next = btn_reg;
                        if (awaiting_reg && btn_reg != 16'd0) begin
                            v_we          = 1'b1;
                            v_wa          = key_dest_reg;
                            v_wd          = {4'd0, c8x_pkg::lowest_key(btn_reg)};
                            awaiting_next = 1'b0;
                        end
                        if (delay_reg != 8'd0) begin
                            delay_next = delay_reg - 8'd1;
                        end
                    end
                    c8x_pkg::CMD_LOAD: begin
                        if (loads_left_reg != 5'd0) begin
                            v_we            = 1'b1;
                            v_wa            = load_tgt_reg;
                            v_wd            = rb_reg;
                            load_tgt_next   = load_tgt_reg + 4'd1;
                            loads_left_next = loads_left_reg - 5'd1;
                        end
                    end
                    c8x_pkg::CMD_COLL: begin
                        v_we = 1'b1;
                        v_wa = 4'hF;
                        v_wd = v_rd | {7'd0, col_reg};
                    end
                    default: err_next = c8x_pkg::ERR_NONE;
                endcase
            end

            c8x_pkg::ST_OPER_B: b_next = v_rd;

            c8x_pkg::ST_EXEC: begin
                emit_req = dec_emit;
                emit_res = dec_res;
                if (go) begin
                    err_next = dec_err;
                    if (dec_err != c8x_pkg::ERR_NONE) begin
                        running_next = 1'b0;
                    end else begin
                        case (op)
                            c8x_pkg::OP_SYS: begin
                                if (instr_reg == c8x_pkg::SYS_RET) begin
                                    depth_next   = depth_reg - 1'b1;
                                    next_pc_next = stk_rd;
                                end else if (instr_reg == c8x_pkg::SYS_LORES) begin
                                    mode_next = c8x_pkg::MODE_PLAIN;
                                end else if (instr_reg == c8x_pkg::SYS_HIRES) begin
                                    mode_next = c8x_pkg::MODE_SCHIP;
                                end
                            end
                            c8x_pkg::OP_JP: begin
                                if (hires_start) begin
                                    mode_next    = c8x_pkg::MODE_HIRES64;
                                    next_pc_next = c8x_pkg::HIRES_TARGET;
                                end else begin
                                    next_pc_next = nnn;
                                end
                            end
                            c8x_pkg::OP_CALL: begin
                                stk_we       = 1'b1;
                                stk_wd       = next_pc_reg;
                                depth_next   = depth_reg + 1'b1;
                                next_pc_next = nnn;
                            end
                            c8x_pkg::OP_SEI:  if (a_reg == nn) next_pc_next = sum;
                            c8x_pkg::OP_SNEI: if (a_reg != nn) next_pc_next = sum;
                            c8x_pkg::OP_SER:  if (a_reg == b_reg) next_pc_next = sum;
                            c8x_pkg::OP_SNER: if (a_reg != b_reg) next_pc_next = sum;
                            c8x_pkg::OP_LDI: begin
                                v_we = 1'b1;
                                v_wd = nn;
                            end
                            c8x_pkg::OP_ADDI: begin
                                v_we = 1'b1;
                                v_wd = a_reg + nn;
                            end
                            c8x_pkg::OP_ALU: begin
                                v_we = 1'b1;
                                case (n)
                                    c8x_pkg::ALU_MOV: v_wd = b_reg;
                                    c8x_pkg::ALU_OR:  v_wd = a_reg | b_reg;
                                    c8x_pkg::ALU_AND: v_wd = a_reg & b_reg;
                                    c8x_pkg::ALU_XOR: v_wd = a_reg ^ b_reg;
                                    c8x_pkg::ALU_ADD: begin
                                        v_wd      = alu_add[7:0];
                                        flag_next = alu_add[8];
                                    end
                                    c8x_pkg::ALU_SUB: begin
                                        v_wd      = a_reg - b_reg;
                                        flag_next = (a_reg >= b_reg);
                                    end
                                    c8x_pkg::ALU_SHR: begin
                                        v_wd      = {1'b0, src[7:1]};
                                        flag_next = src[0];
                                    end
                                    c8x_pkg::ALU_SBN: begin
                                        v_wd      = b_reg - a_reg;
                                        flag_next = (b_reg >= a_reg);
                                    end
                                    c8x_pkg::ALU_SHL: begin
                                        v_wd      = {src[6:0], 1'b0};
                                        flag_next = src[7];
                                    end
                                    default: v_we = 1'b0;
                                endcase
                            end
                            c8x_pkg::OP_LDIX: index_next = nnn;
                            c8x_pkg::OP_JPV0: next_pc_next = sum;
                            c8x_pkg::OP_RND: begin
                                v_we = 1'b1;
                                v_wd = rnd_reg & nn;
                            end
                            c8x_pkg::OP_DRW: begin
                                v_we = 1'b1;
                                v_wa = 4'hF;
                                v_wd = 8'd0;
                            end
                            c8x_pkg::OP_KEY: begin
                                if ((nn == c8x_pkg::KEY_SKP && pressed)
                                    || (nn == c8x_pkg::KEY_SKNP && !pressed)) begin
                                    next_pc_next = sum;
                                end
                            end
                            default: begin
                                loop_idx_next = 4'd0;
                                loop_end_next = x;
                                case (nn)
                                    c8x_pkg::FX_GET_DT: begin
                                        v_we = 1'b1;
                                        v_wd = delay_reg;
                                    end
                                    c8x_pkg::FX_WAIT_K: begin
                                        awaiting_next = 1'b1;
                                        key_dest_next = x;
                                    end
                                    c8x_pkg::FX_SET_DT: delay_next = a_reg;
                                    c8x_pkg::FX_ADD_I:  index_next = sum;
                                    c8x_pkg::FX_FONT:
                                        index_next = {6'd0, a_reg, 2'd0} + {8'd0, a_reg};
                                    c8x_pkg::FX_FONT_B:
                                        index_next = c8x_pkg::FONT_BIG_BASE
                                                     + {5'd0, a_reg, 3'd0}
                                                     + {7'd0, a_reg, 1'b0};
                                    c8x_pkg::FX_BCD: begin
                                        bcd_next      = c8x_pkg::bcd_digits(a_reg);
                                        loop_op_next  = c8x_pkg::LP_BCD;
                                        loop_end_next = 4'd2;
                                    end
                                    c8x_pkg::FX_STORE: loop_op_next = c8x_pkg::LP_STORE;
                                    c8x_pkg::FX_LOAD: begin
                                        loop_op_next    = c8x_pkg::LP_LOAD;
                                        loads_left_next = {1'b0, x} + 5'd1;
                                        load_tgt_next   = 4'd0;
                                    end
                                    c8x_pkg::FX_SAVE: loop_op_next = c8x_pkg::LP_SAVE;
                                    c8x_pkg::FX_REST: loop_op_next = c8x_pkg::LP_RESTORE;
                                    default: loop_op_next = loop_op_reg;
                                endcase
                            end
                        endcase
                    end
                end
            end

            c8x_pkg::ST_FLAG: begin
                v_we = 1'b1;
                v_wa = 4'hF;
                v_wd = {7'd0, flag_reg};
            end

            c8x_pkg::ST_LOOP: begin
                emit_res.addr     = sum;
                emit_res.fetch_pc = next_pc_reg;
                case (loop_op_reg)
                    c8x_pkg::LP_BCD: begin
                        emit_req      = 1'b1;
                        emit_res.kind = c8x_pkg::KIND_WRITE;
                        case (loop_idx_reg[1:0])
                            2'd0:    emit_res.data = {4'd0, bcd_reg[11:8]};
                            2'd1:    emit_res.data = {4'd0, bcd_reg[7:4]};
                            default: emit_res.data = {4'd0, bcd_reg[3:0]};
                        endcase
                    end
                    c8x_pkg::LP_STORE: begin
                        emit_req      = 1'b1;
                        emit_res.kind = c8x_pkg::KIND_WRITE;
                        emit_res.data = v_rd;
                    end
                    c8x_pkg::LP_LOAD: begin
                        emit_req      = 1'b1;
                        emit_res.kind = c8x_pkg::KIND_READ;
                    end
                    c8x_pkg::LP_SAVE: sv_we = 1'b1;
                    c8x_pkg::LP_RESTORE: begin
                        v_we = 1'b1;
                        v_wa = loop_idx_reg;
                        v_wd = sv_rd;
                    end
                    default: emit_req = 1'b0;
                endcase
                if (go) begin
                    loop_idx_next = loop_idx_reg + 4'd1;
                end else begin
                    v_we  = 1'b0;
                    sv_we = 1'b0;
                end
            end

            c8x_pkg::ST_STATUS: begin
                emit_req          = 1'b1;
                emit_res.kind     = c8x_pkg::KIND_STATUS;
                emit_res.error    = err_reg;
                emit_res.fetch_pc = next_pc_reg;
                emit_res.last     = 1'b1;
            end

            default: emit_req = 1'b0;
        endcase

        // configuration writes must arrive only while idle; the block does not enforce this
        if (cfg_wr_en) begin
            case (cfg_addr)
                c8x_pkg::CFG_SHIFT_SRC: shift_x_next = cfg_wdata[0];
                c8x_pkg::CFG_START: begin
                    cur_pc_next  = cfg_wdata;
                    next_pc_next = cfg_wdata;
                end
                default: shift_x_next = shift_x_reg;
            endcase
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        if (emit_req && out_free) begin
            m_valid_next = 1'b1;
            res_next     = emit_res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= c8x_pkg::ST_IDLE;
            shift_x_reg    <= 1'b0;
            index_reg      <= 16'd0;
            cur_pc_reg     <= c8x_pkg::RESET_PC;
            next_pc_reg    <= c8x_pkg::RESET_PC;
            depth_reg      <= '0;
            delay_reg      <= 8'd0;
            key_mask_reg   <= 16'd0;
            awaiting_reg   <= 1'b0;
            key_dest_reg   <= 4'd0;
            running_reg    <= 1'b1;
            mode_reg       <= c8x_pkg::MODE_PLAIN;
            loads_left_reg <= 5'd0;
            load_tgt_reg   <= 4'd0;
            m_valid_reg    <= 1'b0;
            err_reg        <= c8x_pkg::ERR_NONE;
            loop_op_reg    <= c8x_pkg::LP_BCD;
        end else begin
            state_reg      <= state_next;
            shift_x_reg    <= shift_x_next;
            index_reg      <= index_next;
            cur_pc_reg     <= cur_pc_next;
            next_pc_reg    <= next_pc_next;
            depth_reg      <= depth_next;
            delay_reg      <= delay_next;
            key_mask_reg   <= key_mask_next;
            awaiting_reg   <= awaiting_next;
            key_dest_reg   <= key_dest_next;
            running_reg    <= running_next;
            mode_reg       <= mode_next;
            loads_left_reg <= loads_left_next;
            load_tgt_reg   <= load_tgt_next;
            m_valid_reg    <= m_valid_next;
            err_reg        <= err_next;
            loop_op_reg    <= loop_op_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        instr_reg    <= instr_next;
        rnd_reg      <= rnd_next;
        btn_reg      <= btn_next;
        rb_reg       <= rb_next;
        col_reg      <= col_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        flag_reg     <= flag_next;
        bcd_reg      <= bcd_next;
        loop_idx_reg <= loop_idx_next;
        loop_end_reg <= loop_end_next;
        res_reg      <= res_next;
    end

    // V0-VF
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                v_reg[i] <= 8'd0;
            end
        end else if (v_we) begin
            v_reg[v_wa] <= v_wd;
        end
    end

    // RPL save area
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                sv_reg[i] <= 8'd0;
            end
        end else if (sv_we) begin
            sv_reg[loop_idx_reg] <= v_rd;
        end
    end

    // call stack, entries valid once pushed
    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_reg[depth_reg[c8x_pkg::STK_IDX_W-1:0]] <= stk_wd;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_kind     = res_reg.kind;
    assign m_addr     = res_reg.addr;
    assign m_data     = res_reg.data;
    assign m_pos_x    = res_reg.pos_x;
    assign m_pos_y    = res_reg.pos_y;
    assign m_count    = res_reg.count;
    assign m_error    = res_reg.error;
    assign m_fetch_pc = res_reg.fetch_pc;
    assign m_last     = res_reg.last;

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= c8x_pkg::STK_CNT_W'(c8x_pkg::STACK_DEPTH))
        else $error("call stack depth out of range");

    a_loads_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        loads_left_reg <= 5'd16)
        else $error("pending load count out of range");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == c8x_pkg::ST_STATUS && out_free) |=> (m_valid && m_last))
        else $error("status result not presented as last");

    a_err_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == c8x_pkg::ST_STATUS && err_reg != c8x_pkg::ERR_NONE)
        |-> !running_reg)
        else $error("error reported while still running");

endmodule
